### rtl/emb_pkg.sv
package emb_pkg;

	localparam int ACTION_W    = 3;
	localparam int TASK_ID_W   = 3;
	localparam int BITS_W      = 16;
	localparam int KIND_W      = 3;
	localparam int EVT_IDX_W   = 4;
	localparam int LIM_W       = 5;
	localparam int SLOT_LIMIT  = 8;
	localparam int LIMITS_W    = LIM_W * SLOT_LIMIT;
	localparam int PRESENT_W   = SLOT_LIMIT;
	localparam int CFG_IDX_W   = 1;

	localparam logic [LIMITS_W-1:0]  LIMITS_RESET  = 40'h8421084210;
	localparam logic [PRESENT_W-1:0] PRESENT_RESET = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMITS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 1'b1;

	localparam logic [ACTION_W-1:0] ACT_POST  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_KILL  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SCHED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SHORT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_LONG  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EVENT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SHORT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LONG  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IDLE  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [TASK_ID_W-1:0] slot;
		logic [EVT_IDX_W-1:0] index;
		logic                 pend;
	} res_t;

endpackage

### rtl/emb_pick.sv
module emb_pick #(
	parameter int EVENTS = 16
) (
	input  logic [EVENTS-1:0]              word,
	input  logic [emb_pkg::LIM_W-1:0]      limit,
	output logic                           found,
	output logic [emb_pkg::EVT_IDX_W-1:0]  index,
	output logic [EVENTS-1:0]              clear
);

	logic [EVENTS-1:0] eligible;

	// Bits at or above the limit are never chosen; a limit beyond EVENTS acts as EVENTS.
	always_comb begin
		for (int j = 0; j < EVENTS; j++) begin
			eligible[j] = word[j] && (emb_pkg::LIM_W'(j) < limit);
		end
	end

	always_comb begin
		index = '0;
		for (int j = EVENTS - 1; j >= 0; j--) begin
			if (eligible[j]) begin
				index = emb_pkg::EVT_IDX_W'(j);
			end
		end
	end

	assign found = |eligible;
	assign clear = EVENTS'(1) << index;

endmodule

### rtl/emb_mailbox.sv
module emb_mailbox #(
	parameter int TASKS  = 8,
	parameter int EVENTS = 16,
	parameter int IDX_W  = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  addr,
	output logic [EVENTS-1:0] rd_word,
	input  logic              wr_en,
	input  logic [EVENTS-1:0] wr_word,
	output logic [TASKS-1:0]  nz
);

	logic [EVENTS-1:0] mb_q [TASKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TASKS; t++) begin
				mb_q[t] <= '0;
			end
		end else if (wr_en) begin
			mb_q[addr] <= wr_word;
		end
	end

	assign rd_word = mb_q[addr];

	always_comb begin
		for (int t = 0; t < TASKS; t++) begin
			nz[t] = |mb_q[t];
		end
	end

endmodule

### rtl/event_mailbox_priority_dispatcher.sv
// Event mailbox dispatcher with fixed task priority.
// A request is taken at a rising edge with start high and busy low; busy then
// stays high until every result of that request has been given. Results appear
// on kind, task_slot, event_index, pending and last for one cycle each, marked
// by result_strobe; last flags the final result of the request. The receiver
// cannot stall, so no result is ever held back.
// Post, kill, short, long and unknown requests give one acknowledge, made in
// ST_UPDATE and registered out from ST_FINISH. A schedule pass walks the task
// mailboxes one per cycle through a shared lowest-bit pick unit, then the two
// tempo flags; the walk ends early when task 1 has events. One result is held
// back in a register so that last can be marked.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index selecting
// the event limits (0) or the task present mask (1); cfg_ready is always high;
// writes are to be made only while busy is low, which the block does not enforce.
// Reset clears all mailboxes and tempo flags, sets every limit to 16 and marks
// all task slots present.
module event_mailbox_priority_dispatcher #(
	parameter int TASKS  = 8,
	parameter int EVENTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [emb_pkg::ACTION_W-1:0]      action,
	input  logic [emb_pkg::TASK_ID_W-1:0]     task_id,
	input  logic [emb_pkg::BITS_W-1:0]        event_bits,
	output logic                              result_strobe,
	output logic [emb_pkg::KIND_W-1:0]        kind,
	output logic [emb_pkg::TASK_ID_W-1:0]     task_slot,
	output logic [emb_pkg::EVT_IDX_W-1:0]     event_index,
	output logic                              pending,
	output logic                              last,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [emb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [emb_pkg::LIMITS_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(TASKS);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UPDATE = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_TSHORT = 6'b001000,
		ST_TLONG  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [emb_pkg::LIMITS_W-1:0]  limits_q;
	logic [emb_pkg::PRESENT_W-1:0] present_q;
	logic [1:0]                    flags_q, flags_d;
	logic [IDX_W-1:0]              scan_idx_q, scan_idx_d;

	logic [emb_pkg::ACTION_W-1:0]  act_q;
	logic [emb_pkg::TASK_ID_W-1:0] tid_q;
	logic [emb_pkg::BITS_W-1:0]    bits_q;

	emb_pkg::res_t hold_q, gen_res;
	logic          hold_v_q;

	logic [IDX_W-1:0]  addr;
	logic [EVENTS-1:0] rd_word, wr_word;
	logic              wr_en;
	logic [TASKS-1:0]  nz, others_nz;
	logic              pend_next;

	logic                            gen_v;
	logic [emb_pkg::KIND_W-1:0]      gen_kind;
	logic [emb_pkg::TASK_ID_W-1:0]   gen_slot;
	logic [emb_pkg::EVT_IDX_W-1:0]   gen_index;

	logic [emb_pkg::LIM_W-1:0] lim_vec [TASKS];
	logic [TASKS-1:0]          pres_vec;
	logic                      pick_found;
	logic [emb_pkg::EVT_IDX_W-1:0] pick_index;
	logic [EVENTS-1:0]         pick_clear;
	logic                      tid_ok;
	logic                      accept;

	// Slots beyond the register width have a limit of zero and are never present.
	for (genvar t = 0; t < TASKS; t++) begin : g_slot
		if (t < emb_pkg::SLOT_LIMIT) begin : g_cfg
			assign lim_vec[t]  = limits_q[emb_pkg::LIM_W*t +: emb_pkg::LIM_W];
			assign pres_vec[t] = present_q[t];
		end else begin : g_none
			assign lim_vec[t]  = '0;
			assign pres_vec[t] = 1'b0;
		end
	end

	emb_mailbox #(
		.TASKS  (TASKS),
		.EVENTS (EVENTS),
		.IDX_W  (IDX_W)
	) u_mailbox (
		.clk     (clk),
		.arst_n  (arst_n),
		.addr    (addr),
		.rd_word (rd_word),
		.wr_en   (wr_en),
		.wr_word (wr_word),
		.nz      (nz)
	);

	emb_pick #(
		.EVENTS (EVENTS)
	) u_pick (
		.word  (rd_word),
		.limit (lim_vec[scan_idx_q]),
		.found (pick_found),
		.index (pick_index),
		.clear (pick_clear)
	);

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign tid_ok    = (32'(tid_q) < TASKS);

	always_comb begin
		state_d    = state_q;
		scan_idx_d = scan_idx_q;
		flags_d    = flags_q;
		addr       = scan_idx_q;
		wr_en      = 1'b0;
		wr_word    = rd_word;
		gen_v      = 1'b0;
		gen_kind   = emb_pkg::KIND_ACK;
		gen_slot   = '0;
		gen_index  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d    = (action == emb_pkg::ACT_SCHED) ? ST_SCAN : ST_UPDATE;
					scan_idx_d = '0;
				end
			end
			ST_UPDATE: begin
				addr  = IDX_W'(tid_q);
				gen_v = 1'b1;
				case (act_q)
					emb_pkg::ACT_POST: begin
						wr_en   = tid_ok;
						wr_word = rd_word | bits_q[EVENTS-1:0];
					end
					emb_pkg::ACT_KILL: begin
						wr_en   = tid_ok;
						wr_word = rd_word & ~bits_q[EVENTS-1:0];
					end
					emb_pkg::ACT_SHORT: flags_d[0] = 1'b1;
					emb_pkg::ACT_LONG:  flags_d[1] = 1'b1;
					default: begin
					end
				endcase
				state_d = ST_FINISH;
			end
			ST_SCAN: begin
				gen_slot = emb_pkg::TASK_ID_W'(scan_idx_q);
				if (rd_word != '0) begin
					if (!pres_vec[scan_idx_q]) begin
						gen_v    = 1'b1;
						gen_kind = emb_pkg::KIND_ERROR;
					end else if (pick_found) begin
						wr_en     = 1'b1;
						wr_word   = rd_word & ~pick_clear;
						gen_v     = 1'b1;
						gen_kind  = emb_pkg::KIND_EVENT;
						gen_index = pick_index;
					end
				end
				// A busy task 1 ends the walk; otherwise every higher-numbered task gets a turn.
				if ((scan_idx_q == IDX_W'(1) && rd_word != '0) ||
				    scan_idx_q == IDX_W'(TASKS - 1)) begin
					state_d = ST_TSHORT;
				end else begin
					scan_idx_d = scan_idx_q + IDX_W'(1);
				end
			end
			ST_TSHORT: begin
				if (flags_q[0]) begin
					flags_d[0] = 1'b0;
					gen_v      = 1'b1;
					gen_kind   = emb_pkg::KIND_SHORT;
				end
				state_d = ST_TLONG;
			end
			ST_TLONG: begin
				if (flags_q[1]) begin
					flags_d[1] = 1'b0;
					gen_v      = 1'b1;
					gen_kind   = emb_pkg::KIND_LONG;
				end
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The pending flag reflects the mailboxes after this cycle's write.
	assign others_nz = nz & ~(wr_en ? (TASKS'(1) << addr) : TASKS'(0));
	assign pend_next = (|others_nz) || (wr_en && (|wr_word));
	assign gen_res   = '{kind: gen_kind, slot: gen_slot, index: gen_index, pend: pend_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			flags_q    <= '0;
			limits_q   <= emb_pkg::LIMITS_RESET;
			present_q  <= emb_pkg::PRESENT_RESET;
			hold_v_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			scan_idx_q <= scan_idx_d;
			flags_q    <= flags_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					emb_pkg::CFG_LIMITS:  limits_q  <= cfg_data;
					emb_pkg::CFG_PRESENT: present_q <= cfg_data[emb_pkg::PRESENT_W-1:0];
					default: begin
					end
				endcase
			end
			if (gen_v) begin
				hold_v_q <= 1'b1;
			end else if (state_q == ST_FINISH) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			tid_q  <= task_id;
			bits_q <= event_bits;
		end
		if (gen_v) begin
			hold_q <= gen_res;
		end
	end

	// A held result goes out when the next one arrives, or as the last one at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= (gen_v && hold_v_q) || (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (gen_v && hold_v_q) begin
			kind        <= hold_q.kind;
			task_slot   <= hold_q.slot;
			event_index <= hold_q.index;
			pending     <= hold_q.pend;
			last        <= 1'b0;
		end else if (state_q == ST_FINISH) begin
			last <= 1'b1;
			if (hold_v_q) begin
				kind        <= hold_q.kind;
				task_slot   <= hold_q.slot;
				event_index <= hold_q.index;
				pending     <= hold_q.pend;
			end else begin
				kind        <= emb_pkg::KIND_IDLE;
				task_slot   <= '0;
				event_index <= '0;
				pending     <= |nz;
			end
		end
	end

endmodule
